FILE: sv/prq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

    localparam int ID_W    = 5;
    localparam int NUM_IDS = 32;
    localparam int PRIO_W  = 8;
    localparam int COUNT_W = 6;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_PEEK   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ID_W-1:0]   proc_id;
        logic [PRIO_W-1:0] prio;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    out_id;
        logic [PRIO_W-1:0]  out_prio;
        logic               is_empty;
        logic [COUNT_W-1:0] entry_count;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic start;
        logic step;
        logic place;
        logic finish;
    } prq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic reject;
        logic direct;
        logic stop;
        logic is_insert;
    } prq_stat_t;

endpackage

`default_nettype wire

FILE: sv/prq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module prq_datapath #(
    parameter int QUEUE_DEPTH = 32,
    parameter int PRIO_BITS   = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire prq_pkg::in_t      s_data,
    input  wire prq_pkg::prq_cmd_t cmd,
    output prq_pkg::prq_stat_t     stat,
    output prq_pkg::out_t          m_data
);
    import prq_pkg::*;

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int KEEP_W = (PRIO_BITS < PRIO_W) ? PRIO_BITS : PRIO_W;
    localparam int ENT_W  = ID_W + KEEP_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    logic [ENT_W-1:0] mem [QUEUE_DEPTH];

    logic [1:0]         cmd_reg, cmd_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [KEEP_W-1:0]  prio_reg, prio_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [NUM_IDS-1:0] present_reg, present_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [ENT_W-1:0]   rd_data_reg;
    logic               found_reg, found_next;
    logic [ID_W-1:0]    res_id_reg, res_id_next;
    logic [KEEP_W-1:0]  res_prio_reg, res_prio_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    out_t               m_data_reg, m_data_next;

    logic               mem_we, mem_re;
    logic [IDX_W-1:0]   mem_wa;
    logic [ENT_W-1:0]   mem_wd;

    logic               is_ins, is_pop, is_rem, is_peek;
    logic               reject, stop, match, last;
    logic [ID_W-1:0]    rd_id;
    logic [KEEP_W-1:0]  rd_prio;
    logic [CNT_W-1:0]   count_fin;

    assign is_ins  = (cmd_reg == CMD_INSERT);
    assign is_pop  = (cmd_reg == CMD_POP);
    assign is_rem  = (cmd_reg == CMD_REMOVE);
    assign is_peek = (cmd_reg == CMD_PEEK);

    assign rd_id   = rd_data_reg[ENT_W-1 -: ID_W];
    assign rd_prio = rd_data_reg[KEEP_W-1:0];
    assign last    = (CNT_W'(rd_idx_reg) == count_reg - CNT_W'(1));
    assign match   = is_pop ? (rd_idx_reg == '0) : (rd_id == id_reg);

    // presence bitmap answers duplicate and not-found checks up front
    always_comb begin
        if (is_ins) begin
            reject = (count_reg >= DEPTH_C) || present_reg[id_reg];
        end else if (is_rem) begin
            reject = !present_reg[id_reg];
        end else begin
            reject = (count_reg == '0);
        end
    end

    always_comb begin
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        prio_next     = prio_reg;
        count_next    = count_reg;
        present_next  = present_reg;
        addr_next     = addr_reg;
        left_next     = left_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        found_next    = found_reg;
        res_id_next   = res_id_reg;
        res_prio_next = res_prio_reg;
        pos_next      = pos_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_wa        = pos_reg;
        mem_wd        = {id_reg, prio_reg};
        stop          = 1'b0;
        count_fin     = count_reg;

        if (cmd.latch) begin
            cmd_next   = s_data.cmd;
            id_next    = s_data.proc_id;
            prio_next  = s_data.prio[KEEP_W-1:0];
            found_next = 1'b0;
            pos_next   = '0;
        end

        if (cmd.start) begin
            addr_next = is_ins ? IDX_W'(count_reg - CNT_W'(1)) : '0;
            left_next = is_peek ? CNT_W'(1) : count_reg;
        end

        if (cmd.step && rd_vld_reg) begin
            if (is_ins) begin
                // walk from the tail, moving lower priorities up by one
                if (rd_prio < prio_reg) begin
                    mem_we = 1'b1;
                    mem_wa = rd_idx_reg + IDX_W'(1);
                    mem_wd = rd_data_reg;
                    if (rd_idx_reg == '0) begin
                        stop     = 1'b1;
                        pos_next = '0;
                    end
                end else begin
                    stop     = 1'b1;
                    pos_next = rd_idx_reg + IDX_W'(1);
                end
            end else if (is_peek) begin
                stop          = 1'b1;
                res_id_next   = rd_id;
                res_prio_next = rd_prio;
            end else begin
                // walk from the head, closing the gap behind the match
                if (found_reg) begin
                    mem_we = 1'b1;
                    mem_wa = rd_idx_reg - IDX_W'(1);
                    mem_wd = rd_data_reg;
                end else if (match) begin
                    found_next    = 1'b1;
                    res_id_next   = rd_id;
                    res_prio_next = rd_prio;
                end
                stop = last;
            end
        end

        if (cmd.step && (left_reg != '0) && !stop) begin
            mem_re      = 1'b1;
            rd_vld_next = 1'b1;
            rd_idx_next = addr_reg;
            addr_next   = is_ins ? addr_reg - IDX_W'(1) : addr_reg + IDX_W'(1);
            left_next   = left_reg - CNT_W'(1);
        end

        if (cmd.place) begin
            mem_we = 1'b1;
            mem_wa = pos_reg;
            mem_wd = {id_reg, prio_reg};
        end

        if (!reject) begin
            if (is_ins) begin
                count_fin = count_reg + CNT_W'(1);
            end else if (is_pop || is_rem) begin
                count_fin = count_reg - CNT_W'(1);
            end
        end

        if (cmd.finish) begin
            count_next = count_fin;
            if (!reject) begin
                if (is_ins) begin
                    present_next[id_reg] = 1'b1;
                end else if (is_pop || is_rem) begin
                    present_next[res_id_reg] = 1'b0;
                end
            end
            m_data_next.status      = reject ? (is_ins ? ST_FULL : ST_EMPTY) : ST_OK;
            m_data_next.out_id      = reject ? '0 : (is_ins ? id_reg : res_id_reg);
            m_data_next.out_prio    = reject ? '0 :
                                      (is_ins ? PRIO_W'(prio_reg) : PRIO_W'(res_prio_reg));
            m_data_next.is_empty    = (count_fin == '0);
            m_data_next.entry_count = COUNT_W'(count_fin);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            present_reg <= '0;
            rd_vld_reg  <= 1'b0;
            left_reg    <= '0;
        end else begin
            count_reg   <= count_next;
            present_reg <= present_next;
            rd_vld_reg  <= rd_vld_next;
            left_reg    <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        prio_reg     <= prio_next;
        addr_reg     <= addr_next;
        rd_idx_reg   <= rd_idx_next;
        found_reg    <= found_next;
        res_id_reg   <= res_id_next;
        res_prio_reg <= res_prio_next;
        pos_reg      <= pos_next;
        m_data_reg   <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign stat.reject    = reject;
    assign stat.direct    = is_ins && (count_reg == '0);
    assign stat.stop      = stop;
    assign stat.is_insert = is_ins;
    assign m_data         = m_data_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count above queue depth");

    a_bitmap_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(present_reg) == int'(count_reg))
        else $error("presence bitmap disagrees with entry count");

    a_remove_found: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish && !reject && is_rem |-> found_reg)
        else $error("remove finished without locating its id");

endmodule

`default_nettype wire

FILE: sv/prq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module prq_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output prq_pkg::prq_cmd_t       cmd,
    input  wire prq_pkg::prq_stat_t stat
);
    import prq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_PLACE  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (stat.reject) begin
                    state_next = S_FINISH;
                end else if (stat.direct) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.step = 1'b1;
                if (stat.stop) begin
                    state_next = stat.is_insert ? S_PLACE : S_FINISH;
                end
            end
            S_PLACE: begin
                cmd.place  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                // result register must be free before the queue state commits
                if (out_free) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    a_stop_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.stop |-> state_reg == S_SCAN)
        else $error("scan stop outside scan state");

    a_finish_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FINISH && m_valid_reg && !m_ready |=> state_reg == S_FINISH)
        else $error("finish left while result register busy");

    a_place_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PLACE |-> $past(state_reg) == S_START || $past(state_reg) == S_SCAN)
        else $error("place entered from unexpected state");

endmodule

`default_nettype wire

FILE: sv/priority_ready_queue.sv
// Priority ready queue of process ids, highest priority first, arrival order
// among equal priorities.
// Input channel s_valid/s_ready/s_data carries one command per beat: insert,
// pop head, remove by id or peek head. Output channel m_valid/m_ready/m_data
// carries exactly one result beat per command: status, returned id and
// priority, empty flag and entry count after the command.
// Commands are handled one at a time. A refused command (full, duplicate,
// empty, id not queued) skips the walk and goes straight to its result;
// peek reads only the head entry; insert, pop and remove walk the entry
// memory one entry per cycle through its single read port; an insert into
// an empty queue is placed without a walk.
// The next command is accepted the cycle after the previous result is loaded.
// The result sits in an output register: a stalled receiver does not block
// acceptance of the next command, which finishes only once that register
// has been taken.
// Synchronous reset empties the queue at once; no clearing pass is needed
// since only occupied entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module priority_ready_queue #(
    parameter int QUEUE_DEPTH = 32,
    parameter int PRIO_BITS   = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire prq_pkg::in_t s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output prq_pkg::out_t     m_data
);
    import prq_pkg::*;

    prq_cmd_t  cmd;
    prq_stat_t stat;

    prq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    prq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PRIO_BITS   (PRIO_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
